// ----- src/cpa_pkg.sv -----
// Shared widths, step counts and unit status type for the closure phase accumulator.
`default_nettype none
package cpa_pkg;

    localparam int AMP_W    = 16;   // amplitude and weight fields
    localparam int MCAND_W  = 32;   // widest multiplicand (amplitude squared)
    localparam int PROD_W   = 48;   // weight * amplitude^2
    localparam int REM_W    = 48;   // divider remainder, below the divisor
    localparam int QUO_W    = 57;   // quotient of 2^56 needs 57 bits
    localparam int TERM_W   = 41;   // 2^40 / prod is at most 2^40
    localparam int VAR_W    = 42;   // variance sum, modulo 2^42
    localparam int WEIGHT_W = 48;   // closure weight
    localparam int STEP_W   = 6;    // divider step counter
    localparam int MCNT_W   = 4;    // multiplier step counter

    // quotient bits produced for 2^40 / prod and 2^56 / sum
    localparam logic [STEP_W-1:0] TERM_STEPS   = 6'd41;
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = 6'd57;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, result stable from here on
    } t_unit_stat;

endpackage
`default_nettype wire

// ----- src/cpa_serial_mult.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
`default_nettype none
module cpa_serial_mult
    import cpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MCAND_W-1:0] i_mcand,
    input  wire logic [AMP_W-1:0]   i_mplier,
    output t_unit_stat              o_stat,
    output logic [PROD_W-1:0]       o_product
);

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [AMP_W-1:0]  r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(AMP_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[AMP_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule
`default_nettype wire

// ----- src/cpa_recip_div.sv -----
// Restoring radix-2 divider for 2^(steps-1) / divisor, one quotient bit per cycle.
`default_nettype none
module cpa_recip_div
    import cpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_divisor,
    input  wire logic [STEP_W-1:0] i_steps,
    output t_unit_stat             o_stat,
    output logic [QUO_W-1:0]       o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic              r_first;     // dividend is a single one bit, fed first
    logic [REM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_div;
    logic [QUO_W-1:0]  r_quo;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              q_bit;

    always_comb begin
        trial = {r_rem, r_first};
        diff  = trial - {1'b0, r_div};
        q_bit = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps - 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_div   <= i_divisor;
            r_quo   <= '0;
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_rem   <= q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];
            r_quo   <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
`default_nettype wire

// ----- src/closure_phase_accumulator_unit.sv -----
// Top level: closure phase, flags and weight of one baseline triangle.
//
// Input channel (i_in_valid / o_in_stall) takes the three visibilities of a
// triangle as three successive transfers. The result channel (o_out_valid /
// i_out_stall) gives one closure after every third transfer.
// A usable visibility holds the input stalled from its transfer until the next
// one can be taken: two passes of the bit-serial multiplier form
// weight * amplitude^2, then the radix-2 divider computes 2^40 / product.
// A deleted visibility, or one with zero amplitude or weight, skips both
// units. After the third visibility the same divider computes 2^56 / variance
// sum (skipped for a deleted closure or a zero variance sum), and the result
// then passes through state S_FIN into the output register.
// The result sits in an output register; the next triangle is taken while it
// waits. If the receiver still stalls when the following result is ready,
// the block holds that result internally and stalls its input.
// Synchronous reset clears the item count, the sums, the flags and the output
// valid; no result is pending after reset.
`default_nettype none
module closure_phase_accumulator_unit
    import cpa_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_vis_sign,
    input  wire logic signed [PHASE_BITS-1:0] i_obs_phase,
    input  wire logic signed [PHASE_BITS-1:0] i_model_phase,
    input  wire logic [AMP_W-1:0]             i_amplitude,
    input  wire logic [AMP_W-1:0]             i_vis_weight,
    input  wire logic                         i_is_deleted,
    input  wire logic                         i_is_bad,
    input  wire logic                         i_is_other_flagged,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [PHASE_BITS-1:0]      o_obs_closure,
    output logic signed [PHASE_BITS-1:0]      o_model_closure,
    output logic [WEIGHT_W-1:0]               o_closure_weight,
    output logic                              o_closure_deleted,
    output logic                              o_closure_bad,
    output logic                              o_closure_corrected
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_DIVT  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [1:0] LAST_ITEM = 2'd3;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [1:0]            r_count;
    logic [PHASE_BITS-1:0] r_obs_sum;
    logic [PHASE_BITS-1:0] r_model_sum;
    logic [VAR_W-1:0]      r_var_sum;
    logic                  r_f_del;
    logic                  r_f_bad;
    logic                  r_f_cor;
    logic [AMP_W-1:0]      r_wt;
    logic [WEIGHT_W-1:0]   r_weight;

    logic                  r_out_valid;
    logic [PHASE_BITS-1:0] r_out_obs;
    logic [PHASE_BITS-1:0] r_out_model;
    logic [WEIGHT_W-1:0]   r_out_weight;
    logic                  r_out_del;
    logic                  r_out_bad;
    logic                  r_out_cor;

    logic                  in_xfer;
    logic                  usable;
    logic                  out_free;
    logic                  closure_zero;

    logic                  mul_start;
    logic [MCAND_W-1:0]    mul_mcand;
    logic [AMP_W-1:0]      mul_mplier;
    t_unit_stat            mul_stat;
    logic [PROD_W-1:0]     mul_product;

    logic                  div_start;
    logic [PROD_W-1:0]     div_divisor;
    logic [STEP_W-1:0]     div_steps;
    t_unit_stat            div_stat;
    logic [QUO_W-1:0]      div_quotient;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_xfer      = i_in_valid && !o_in_stall;
    assign usable       = !i_is_deleted && (i_amplitude != '0) && (i_vis_weight != '0);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign closure_zero = r_f_del || (r_var_sum == '0);

    // pass one: amplitude * amplitude, pass two: amplitude^2 * weight
    always_comb begin
        mul_start  = (in_xfer && usable) || (r_state == S_MUL1 && mul_stat.done);
        mul_mcand  = (r_state == S_IDLE) ? MCAND_W'(i_amplitude) : mul_product[MCAND_W-1:0];
        mul_mplier = (r_state == S_IDLE) ? i_amplitude : r_wt;
    end

    always_comb begin
        div_start = (r_state == S_MUL2 && mul_stat.done)
                 || (r_state == S_CHECK && r_count == LAST_ITEM && !closure_zero);
        if (r_state == S_MUL2) begin
            div_divisor = mul_product;
            div_steps   = TERM_STEPS;
        end else begin
            div_divisor = PROD_W'(r_var_sum);
            div_steps   = WEIGHT_STEPS;
        end
    end

    cpa_serial_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_stat    (mul_stat),
        .o_product (mul_product)
    );

    cpa_recip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = usable ? S_MUL1 : S_CHECK;
                end
            end
            S_MUL1: begin
                if (mul_stat.done) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mul_stat.done) begin
                    n_state = S_DIVT;
                end
            end
            S_DIVT: begin
                if (div_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_count != LAST_ITEM) begin
                    n_state = S_IDLE;
                end else if (closure_zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_stat.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_obs_sum   <= '0;
            r_model_sum <= '0;
            r_var_sum   <= '0;
            r_f_del     <= 1'b0;
            r_f_bad     <= 1'b0;
            r_f_cor     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_count <= r_count + 1'b1;
                if (i_vis_sign) begin
                    r_obs_sum   <= r_obs_sum - $unsigned(i_obs_phase);
                    r_model_sum <= r_model_sum - $unsigned(i_model_phase);
                end else begin
                    r_obs_sum   <= r_obs_sum + $unsigned(i_obs_phase);
                    r_model_sum <= r_model_sum + $unsigned(i_model_phase);
                end
                if (!usable) begin
                    r_f_del <= 1'b1;
                end else if (i_is_bad) begin
                    r_f_bad <= 1'b1;
                end else if (i_is_other_flagged) begin
                    r_f_cor <= 1'b1;
                end
            end
            if (r_state == S_DIVT && div_stat.done) begin
                r_var_sum <= r_var_sum + VAR_W'(div_quotient[TERM_W-1:0]);
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_obs_sum   <= '0;
                r_model_sum <= '0;
                r_var_sum   <= '0;
                r_f_del     <= 1'b0;
                r_f_bad     <= 1'b0;
                r_f_cor     <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_wt <= i_vis_weight;
        end
        if (r_state == S_CHECK) begin
            r_weight <= '0;
        end else if (r_state == S_DIVW && div_stat.done) begin
            // 2^56 / sum at or above 2^48 saturates
            r_weight <= (div_quotient[QUO_W-1:WEIGHT_W] != '0) ? WEIGHT_MAX
                                                                : div_quotient[WEIGHT_W-1:0];
        end
        if (r_state == S_FIN && out_free) begin
            r_out_obs    <= r_obs_sum;
            r_out_model  <= r_model_sum;
            r_out_weight <= r_weight;
            r_out_del    <= r_f_del;
            r_out_bad    <= r_f_bad;
            r_out_cor    <= r_f_cor;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_obs_closure       = $signed(r_out_obs);
    assign o_model_closure     = $signed(r_out_model);
    assign o_closure_weight    = r_out_weight;
    assign o_closure_deleted   = r_out_del;
    assign o_closure_bad       = r_out_bad;
    assign o_closure_corrected = r_out_cor;

endmodule
`default_nettype wire

// ----- src/cpa_checker.sv -----
// Port-level checks for the closure phase accumulator, bound to the top level.
`default_nettype none
module cpa_checker
    import cpa_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [PHASE_BITS-1:0] o_obs_closure,
    input wire logic signed [PHASE_BITS-1:0] o_model_closure,
    input wire logic [WEIGHT_W-1:0]          o_closure_weight,
    input wire logic                         o_closure_deleted
);

    // every transfer starts work, so the input stalls right after it
    a_stall_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    a_deleted_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_closure_deleted) |-> (o_closure_weight == '0))
        else $error("deleted closure with nonzero weight");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_obs_closure) && $stable(o_model_closure)
             && $stable(o_closure_weight)))
        else $error("stalled result changed");

endmodule

bind closure_phase_accumulator_unit cpa_checker #(.PHASE_BITS(PHASE_BITS)) u_cpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_obs_closure     (o_obs_closure),
    .o_model_closure   (o_model_closure),
    .o_closure_weight  (o_closure_weight),
    .o_closure_deleted (o_closure_deleted)
);
`default_nettype wire
